>>> sv/matrix_determinant_cofactor_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the determinant block
// Shared concurrent assertion wrappers, clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef MATRIX_DETERMINANT_COFACTOR_TOP_MACROS_SVH
`define MATRIX_DETERMINANT_COFACTOR_TOP_MACROS_SVH

// checked outside reset only
`define DMC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every edge, reset included
`define DMC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

>>> sv/dmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_pkg
// Types, constants and width helpers for the determinant block.
// ----------------------------------------------------------------------------
package dmc_pkg;

   localparam int MAX_SIZE_DEF = 4;
   localparam int ELEMENT_BITS = 16;
   localparam int FRAC_BITS    = 8;
   localparam int CSR_W        = 3;
   localparam int DET_W        = 64;
   localparam int LIMB_BITS    = 32;

   localparam logic signed [DET_W-1:0] DET_MAX = {1'b0, {(DET_W-1){1'b1}}};
   localparam logic signed [DET_W-1:0] DET_MIN = {1'b1, {(DET_W-1){1'b0}}};

   typedef struct packed {
      logic signed [ELEMENT_BITS-1:0] element_value;
      logic                           last_element;
   } req_type;

   typedef struct packed {
      logic signed [DET_W-1:0] determinant;
      logic                    overflow;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic issue;
      logic negate;
   } mac_ctrl_type;

   // Wide enough for any scaled determinant plus headroom for the 64-bit
   // saturation check.
   function automatic int acc_width(int max_size);
      int dig;
      int raw;
      dig = (ELEMENT_BITS > 9) ? ELEMENT_BITS : 9;
      raw = dig * max_size + 12;
      return (raw > DET_W + 2) ? raw : DET_W + 2;
   endfunction

endpackage

>>> sv/matrix_determinant_cofactor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_determinant_cofactor_top
// Determinant of an n x n Q8.8 matrix by cofactor expansion along the
// first row, evaluated bottom up over column subsets with one shared MAC.
// ----------------------------------------------------------------------------
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+---------------------------------
//  request  | start, busy, req_data         | beat taken when start && !busy
//  response | rsp_valid, rsp_data           | one-cycle strobe, no back pressure
//  csr      | csr_wr_en, csr_wr_data        | matrix_size written when wr_en
//
// Flow: elements load one beat per cycle while busy is low. The beat with
// last_element set starts the computation; busy then stays high while the
// single limb MAC handles every element x minor product one 32-bit limb a
// cycle (LIMBS = 3 at the default widths), until the full subset is written.
// The result strobe follows in the first cycle with busy low.
// Reset: synchronous, clears control state and sets matrix_size to MAX_SIZE.
// The receiver cannot stall; each result is shown for exactly one cycle.
//
// Method: M[S] is the determinant of the trailing rows restricted to column
// set S. With M[empty] = 1, M[S] = sum over c in S of +/- a[n-|S|][c] *
// M[S - c], sign alternating over the set bits of S. Subsets are walked in
// increasing order, so every smaller minor is already in the minor memory.
// ----------------------------------------------------------------------------
`include "matrix_determinant_cofactor_top_macros.svh"

module matrix_determinant_cofactor_top #(
   parameter int MAX_SIZE = dmc_pkg::MAX_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  dmc_pkg::req_type            req_data,
   output logic                        rsp_valid,
   output dmc_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [dmc_pkg::CSR_W-1:0]   csr_wr_data
);
   import dmc_pkg::*;

   localparam int DEPTH     = MAX_SIZE * MAX_SIZE;
   localparam int STORE_AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int SIZE_W    = $clog2(MAX_SIZE + 1);
   localparam int ACC_W     = acc_width(MAX_SIZE);
   localparam int LIMBS     = (ACC_W + LIMB_BITS - 1) / LIMB_BITS;
   localparam int LIMB_W    = $clog2(LIMBS + 1);
   localparam int MEM_DEPTH = 2 ** MAX_SIZE;
   localparam int SHAMT_W   = $clog2(FRAC_BITS * MAX_SIZE + 1);

   // sequencer states
   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;  // loading elements
   localparam logic [ST_W-1:0] ST_INIT  = 3'd1;  // seed M[empty] = 1
   localparam logic [ST_W-1:0] ST_SCAN  = 3'd2;  // pick next column of S
   localparam logic [ST_W-1:0] ST_MUL   = 3'd3;  // limb products
   localparam logic [ST_W-1:0] ST_WRITE = 3'd4;  // store M[S], maybe emit

   logic [ST_W-1:0]               state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [CSR_W-1:0]              csr_size_ff, csr_size_in;
   logic [SIZE_W-1:0]             n_ff, n_in;
   logic [MAX_SIZE-1:0]           subset_ff, subset_in;
   logic [SIZE_W-1:0]             col_ff, col_in;
   logic [LIMB_W-1:0]             limb_ff, limb_in;
   logic                          parity_ff, parity_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_data_ff, rsp_data_in;

   logic signed [ELEMENT_BITS-1:0] store_mem_ff [DEPTH];
   logic [ACC_W-1:0]               minor_mem_ff [MEM_DEPTH];
   logic signed [ELEMENT_BITS-1:0] elem_rd_ff;
   logic [ACC_W-1:0]               minor_rd_ff;

   logic                          accept;
   logic [SIZE_W-1:0]             size_cur;
   logic [CNT_W-1:0]              nn_cur;
   logic                          store_we;
   logic [SIZE_W-1:0]             pop;
   logic [SIZE_W-1:0]             row;
   logic [MAX_SIZE-1:0]           col_bit;
   logic                          col_sel;
   logic [MAX_SIZE-1:0]           minor_ra;
   logic [CNT_W-1:0]              elem_idx;
   logic [MAX_SIZE:0]             full_ext;
   logic                          subset_full;
   logic                          rd_en;
   logic                          mw_en;
   logic [MAX_SIZE-1:0]           mw_addr;
   logic [ACC_W-1:0]              mw_data;
   mac_ctrl_type                  mac_ctrl;
   logic [ACC_W-1:0]              mac_acc;
   logic [SHAMT_W-1:0]            shamt;
   logic [ACC_W-1:0]              scaled;
   logic [ACC_W-DET_W:0]          upper;
   logic                          fits;

   // ---- load side ---------------------------------------------------------
   assign accept = start && !busy;

   // zero runs as 1x1, anything above MAX_SIZE as MAX_SIZE
   always_comb begin
      priority if (csr_size_ff == '0) begin
         size_cur = SIZE_W'(1);
      end else if (csr_size_ff > CSR_W'(MAX_SIZE)) begin
         size_cur = SIZE_W'(MAX_SIZE);
      end else begin
         size_cur = SIZE_W'(csr_size_ff);
      end
   end

   assign nn_cur   = CNT_W'(size_cur) * CNT_W'(size_cur);
   assign store_we = accept && (cnt_ff < nn_cur);

   // ---- expansion addressing ----------------------------------------------
   always_comb begin
      pop = '0;
      for (int i = 0; i < MAX_SIZE; i++) begin
         pop = pop + SIZE_W'(subset_ff[i]);
      end
   end

   assign row         = n_ff - pop;
   assign col_bit     = MAX_SIZE'(1) << col_ff;
   assign col_sel     = |(subset_ff & col_bit);
   assign minor_ra    = subset_ff & ~col_bit;
   assign elem_idx    = CNT_W'(row) * CNT_W'(n_ff) + CNT_W'(col_ff);
   assign full_ext    = ((MAX_SIZE + 1)'(1) << n_ff) - (MAX_SIZE + 1)'(1);
   assign subset_full = (subset_ff == full_ext[MAX_SIZE-1:0]);
   assign rd_en       = (state_ff == ST_SCAN) && (col_ff != n_ff) && col_sel;

   // ---- final scaling to 8*MAX_SIZE fraction bits and saturation ----------
   assign shamt  = SHAMT_W'(FRAC_BITS * MAX_SIZE) - SHAMT_W'(FRAC_BITS) * SHAMT_W'(n_ff);
   assign scaled = mac_acc << shamt;
   assign upper  = scaled[ACC_W-1:DET_W-1];
   assign fits   = (&upper) | ~(|upper);

   // ---- sequencer ---------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      csr_size_in  = csr_size_ff;
      n_in         = n_ff;
      subset_in    = subset_ff;
      col_in       = col_ff;
      limb_in      = limb_ff;
      parity_in    = parity_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mw_en        = 1'b0;
      mw_addr      = subset_ff;
      mw_data      = mac_acc;
      mac_ctrl     = '0;

      if (csr_wr_en) begin
         csr_size_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (store_we) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (req_data.last_element) begin
                  cnt_in   = '0;
                  n_in     = size_cur;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            mw_en          = 1'b1;
            mw_addr        = '0;
            mw_data        = ACC_W'(1);
            mac_ctrl.clear = 1'b1;
            subset_in      = MAX_SIZE'(1);
            col_in         = '0;
            parity_in      = 1'b0;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (col_ff == n_ff) begin
               state_in = ST_WRITE;
            end else if (col_sel) begin
               limb_in  = '0;
               state_in = ST_MUL;
            end else begin
               col_in = col_ff + SIZE_W'(1);
            end
         end
         ST_MUL: begin
            mac_ctrl.issue  = 1'b1;
            mac_ctrl.negate = parity_ff;
            if (limb_ff == LIMB_W'(LIMBS - 1)) begin
               limb_in   = '0;
               col_in    = col_ff + SIZE_W'(1);
               parity_in = ~parity_ff;
               state_in  = ST_SCAN;
            end else begin
               limb_in = limb_ff + LIMB_W'(1);
            end
         end
         ST_WRITE: begin
            mw_en = 1'b1;
            if (subset_full) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.overflow    = ~fits;
               rsp_data_in.determinant = fits ? scaled[DET_W-1:0]
                                              : (scaled[ACC_W-1] ? DET_MIN : DET_MAX);
               state_in                = ST_IDLE;
            end else begin
               mac_ctrl.clear = 1'b1;
               subset_in      = subset_ff + MAX_SIZE'(1);
               col_in         = '0;
               parity_in      = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         csr_size_ff  <= CSR_W'(MAX_SIZE);
         n_ff         <= SIZE_W'(MAX_SIZE);
         subset_ff    <= '0;
         col_ff       <= '0;
         limb_ff      <= '0;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         csr_size_ff  <= csr_size_in;
         n_ff         <= n_in;
         subset_ff    <= subset_in;
         col_ff       <= col_in;
         limb_ff      <= limb_in;
         parity_ff    <= parity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // ---- element store and minor memory ------------------------------------
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem_ff[cnt_ff[STORE_AW-1:0]] <= req_data.element_value;
      end
      if (rd_en) begin
         elem_rd_ff <= store_mem_ff[elem_idx[STORE_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (mw_en) begin
         minor_mem_ff[mw_addr] <= mw_data;
      end
      if (rd_en) begin
         minor_rd_ff <= minor_mem_ff[minor_ra];
      end
   end

   // ---- shared multiply-accumulate ----------------------------------------
   dmc_mac #(
      .MAX_SIZE (MAX_SIZE)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .limb_sel (limb_ff),
      .element  (elem_rd_ff),
      .minor    (minor_rd_ff),
      .acc      (mac_acc)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- assertions --------------------------------------------------------
   `DMC_ASSERT_ALWAYS(a_reset_quiet, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "reset left block active")
   `DMC_ASSERT(a_rsp_from_write, rsp_valid_ff |-> ($past(state_ff == ST_WRITE) && !busy), "result strobe without final write")
   `DMC_ASSERT(a_last_starts, (accept && req_data.last_element) |=> (state_ff == ST_INIT && cnt_ff == '0), "last beat did not start expansion")
   `DMC_ASSERT(a_count_bound, cnt_ff <= CNT_W'(DEPTH), "element count beyond store depth")
   `DMC_ASSERT(a_ovf_saturated, (rsp_valid_ff && rsp_data_ff.overflow) |-> (rsp_data_ff.determinant == DET_MAX || rsp_data_ff.determinant == DET_MIN), "overflow without saturated value")

endmodule

>>> sv/dmc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_mac
// Shared limb multiply-accumulate: element x one 32-bit limb of a minor,
// registered, then shifted into place and added to or taken from the sum.
// ----------------------------------------------------------------------------
module dmc_mac #(
   parameter int MAX_SIZE = dmc_pkg::MAX_SIZE_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  dmc_pkg::mac_ctrl_type                          ctrl,
   input  logic [$clog2((dmc_pkg::acc_width(MAX_SIZE) + dmc_pkg::LIMB_BITS - 1)
                        / dmc_pkg::LIMB_BITS + 1)-1:0]     limb_sel,
   input  logic signed [dmc_pkg::ELEMENT_BITS-1:0]        element,
   input  logic [dmc_pkg::acc_width(MAX_SIZE)-1:0]        minor,
   output logic [dmc_pkg::acc_width(MAX_SIZE)-1:0]        acc
);
   import dmc_pkg::*;

   localparam int ACC_W  = acc_width(MAX_SIZE);
   localparam int LIMBS  = (ACC_W + LIMB_BITS - 1) / LIMB_BITS;
   localparam int LIMB_W = $clog2(LIMBS + 1);
   localparam int EXT_W  = LIMBS * LIMB_BITS;
   localparam int PROD_W = ELEMENT_BITS + LIMB_BITS + 1;
   localparam int SUM_W  = EXT_W + PROD_W;

   logic signed [EXT_W-1:0]     minor_ext;
   logic [LIMB_BITS-1:0]        limb;
   logic signed [LIMB_BITS:0]   limb_s;
   logic signed [PROD_W-1:0]    prod_in, prod_ff;
   logic [LIMB_W-1:0]           shift_in, shift_ff;
   logic                        neg_in, neg_ff;
   logic                        vld_in, vld_ff;
   logic [SUM_W-1:0]            addend_ext;
   logic [ACC_W-1:0]            addend;
   logic [ACC_W-1:0]            acc_in, acc_ff;

   assign minor_ext = EXT_W'(signed'(minor));
   assign limb      = minor_ext[LIMB_BITS*limb_sel +: LIMB_BITS];
   // top limb carries the sign, lower limbs are unsigned
   assign limb_s    = (limb_sel == LIMB_W'(LIMBS - 1)) ? {limb[LIMB_BITS-1], limb}
                                                       : {1'b0, limb};
   assign prod_in   = PROD_W'(element) * PROD_W'(limb_s);
   assign shift_in  = limb_sel;
   assign neg_in    = ctrl.negate;
   assign vld_in    = ctrl.issue;

   assign addend_ext = SUM_W'(prod_ff) << (shift_ff * LIMB_BITS);
   assign addend     = addend_ext[ACC_W-1:0];

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (vld_ff) begin
         acc_in = neg_ff ? (acc_ff - addend) : (acc_ff + addend);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         acc_ff <= acc_in;
      end
      prod_ff  <= prod_in;
      shift_ff <= shift_in;
      neg_ff   <= neg_in;
   end

   assign acc = acc_ff;

endmodule

>>> test/tb_matrix_determinant_cofactor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_determinant_cofactor_top
// Streams square Q8.8 matrices into the determinant block and compares
// every result beat with an exact wide-integer determinant of the same data.
// ----------------------------------------------------------------------------
module tb_matrix_determinant_cofactor_top;
   import dmc_pkg::*;

   localparam int ORDER_MAX   = MAX_SIZE_DEF;
   localparam int CELLS       = ORDER_MAX * ORDER_MAX;
   localparam int WIDE        = 128;      // exact products of up to 4 elements
   localparam int SETTLE      = 220;      // longer than a full-size expansion
   localparam int RAND_BEATS  = 850;
   localparam int CYCLE_LIMIT = 1000000;

   typedef enum int unsigned {
      FILL_UNIFORM,
      FILL_EXTREME,
      FILL_SMALL,
      FILL_SPARSE
   } fill_style_type;

   // ------------------------------------------------------------------------
   // Block hookup; every input has a known value from time zero
   // ------------------------------------------------------------------------
   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   logic             busy;
   req_type          req_data    = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = '0;

   matrix_determinant_cofactor_top #(
      .MAX_SIZE(ORDER_MAX)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor state: mirror of the element store, fill count and size CSR
   // ------------------------------------------------------------------------
   logic signed [ELEMENT_BITS-1:0] element_ram [CELLS];
   int unsigned                    elements_held;
   logic [CSR_W-1:0]               size_csr;
   rsp_type                        expected_dets [$];
   rsp_type                        oldest_det;

   // run bookkeeping
   int unsigned mismatches   = 0;
   int unsigned dets_checked = 0;
   int unsigned beats_sent   = 0;
   int unsigned random_beats = 0;
   int unsigned saturations  = 0;
   int unsigned order_hits [1:ORDER_MAX];
   int unsigned cycle_count  = 0;
   bit          no_idle      = 1'b0;

   // Register value to matrix order: 0 behaves as 1, anything past the
   // maximum behaves as the maximum.
   function automatic int unsigned active_order();
      if (size_csr == 0)
         return 1;
      if (size_csr > ORDER_MAX)
         return ORDER_MAX;
      return int'(size_csr);
   endfunction

   // Exact determinant over the first n*n cells (row-major at order n).
   // Sum over all permutations, sign from the inversion count; this equals
   // the first-row cofactor expansion and needs no recursion.
   function automatic logic signed [WIDE-1:0] exact_det(int unsigned n);
      logic signed [WIDE-1:0] sum;
      logic signed [WIDE-1:0] prod;
      int unsigned            pick [ORDER_MAX];
      int unsigned            code;
      int unsigned            used;
      int unsigned            swaps;
      bit                     distinct;
      sum = '0;
      for (int unsigned t = 0; t < n ** n; t++) begin
         code     = t;
         used     = 0;
         distinct = 1'b1;
         for (int unsigned r = 0; r < n; r++) begin
            pick[r] = code % n;
            code    = code / n;
            if (used[pick[r]])
               distinct = 1'b0;
            used[pick[r]] = 1'b1;
         end
         if (distinct) begin
            prod  = 1;
            swaps = 0;
            for (int unsigned r = 0; r < n; r++)
               prod = prod * element_ram[r * n + pick[r]];
            for (int unsigned i = 0; i < n; i++)
               for (int unsigned j = i + 1; j < n; j++)
                  if (pick[i] > pick[j])
                     swaps++;
            sum = swaps[0] ? sum - prod : sum + prod;
         end
      end
      return sum;
   endfunction

   // Advance the mirror by one accepted beat; a last beat queues a result.
   function automatic void predict_beat(req_type beat);
      int unsigned            n;
      logic signed [WIDE-1:0] scaled;
      rsp_type                det_rsp;
      n = active_order();
      // beats past a full matrix are dropped
      if (elements_held < n * n) begin
         element_ram[elements_held] = beat.element_value;
         elements_held++;
      end
      if (!beat.last_element)
         return;
      // rescale from 8*n to 8*ORDER_MAX fraction bits, then saturate
      scaled = exact_det(n) <<< (FRAC_BITS * (ORDER_MAX - n));
      if (scaled > DET_MAX) begin
         det_rsp.determinant = DET_MAX;
         det_rsp.overflow    = 1'b1;
      end else if (scaled < DET_MIN) begin
         det_rsp.determinant = DET_MIN;
         det_rsp.overflow    = 1'b1;
      end else begin
         det_rsp.determinant = scaled[DET_W-1:0];
         det_rsp.overflow    = 1'b0;
      end
      saturations += det_rsp.overflow;
      order_hits[n]++;
      elements_held = 0;
      expected_dets.push_back(det_rsp);
   endfunction

   // ------------------------------------------------------------------------
   // Result checking; no back pressure, so every strobe is a beat
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [DET_W-1:0] got,
                                  logic [DET_W-1:0] want);
      mismatches++;
      $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
   endtask

   // Outputs are read right after the edge, i.e. their pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_dets.size() == 0) begin
            report_mismatch("result beat with nothing pending", rsp_data.determinant, '0);
         end else begin
            oldest_det = expected_dets.pop_front();
            if (rsp_data.determinant !== oldest_det.determinant)
               report_mismatch("determinant", rsp_data.determinant, oldest_det.determinant);
            if (rsp_data.overflow !== oldest_det.overflow)
               report_mismatch("overflow flag", DET_W'(rsp_data.overflow),
                               DET_W'(oldest_det.overflow));
            dets_checked++;
         end
      end
   end

   // Watchdog: a hung block or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("matrix_determinant_cofactor_top: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [ELEMENT_BITS-1:0] pick_element(fill_style_type style);
      int v;
      // any style lets a fully random value through now and then
      if ($urandom_range(0, 9) == 0)
         style = FILL_UNIFORM;
      case (style)
         FILL_EXTREME: begin
            case ($urandom_range(0, 5))
               0: v = 16'h7FFF;
               1: v = 16'h8000;
               2: v = 16'h8001;
               3: v = 16'hFFFF;
               4: v = 16'h0100;
               default: v = 0;
            endcase
         end
         FILL_SMALL: v = $urandom_range(0, 2047) - 1024;   // within +/-4.0
         FILL_SPARSE: v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : 0;
         default: v = $urandom_range(0, 65535);
      endcase
      return v[ELEMENT_BITS-1:0];
   endfunction

   // One request beat. start stays high on return so the next call can
   // follow in the same step; anything that lets time pass lowers it first.
   task automatic send_element(logic signed [ELEMENT_BITS-1:0] value, bit last);
      int unsigned gap;
      req_type     beat;
      gap               = pick_gap();
      beat.element_value = value;
      beat.last_element  = last;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      do
         @(posedge clock);
      while (busy);
      predict_beat(beat);
      beats_sent++;
   endtask

   // Hold the sender until every pending result is in, then let any
   // expansion still running finish.
   task automatic wait_drained();
      start <= 1'b0;
      while (expected_dets.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_size(logic [CSR_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      size_csr   = value;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // 4x4 Hadamard pattern at +/-32767: fills every cell of the store and
   // lands above the 64-bit range, so it must saturate high.
   task automatic test_full_order();
      for (int r = 0; r < ORDER_MAX; r++)
         for (int c = 0; c < ORDER_MAX; c++)
            send_element($countones(r & c) % 2 ? -16'sd32767 : 16'sd32767,
                         r == ORDER_MAX - 1 && c == ORDER_MAX - 1);
   endtask

   // Short matrix: only the first row is rewritten (negated), the rest is
   // left over from before; the determinant flips and saturates low.
   task automatic test_short_matrix();
      for (int c = 0; c < ORDER_MAX; c++)
         send_element(-16'sd32767, c == ORDER_MAX - 1);
   endtask

   // Order one, both directly and through the zero register value; the
   // extra beats after a full 1x1 matrix are dropped.
   task automatic test_order_one();
      write_size(3'd1);
      send_element(16'sh8000, 1'b1);
      write_size(3'd0);
      send_element(16'sh7FFF, 1'b1);
      send_element(16'sh0100, 1'b0);
      send_element(16'shFFFF, 1'b0);
      send_element(16'sh1234, 1'b1);
   endtask

   task automatic test_order_two();
      write_size(3'd2);
      send_element(16'sh7FFF, 1'b0);
      send_element(16'sh8000, 1'b0);
      send_element(16'sh8000, 1'b0);
      send_element(16'sh7FFF, 1'b1);
   endtask

   // Size shrinks from 3 to 2 after three beats; the fourth beat closes a
   // 2x2 matrix read at the new order.
   task automatic test_size_change_mid_matrix();
      write_size(3'd3);
      send_element(16'sh0180, 1'b0);
      send_element(16'shFE40, 1'b0);
      send_element(16'sh0300, 1'b0);
      write_size(3'd2);
      send_element(16'sh0050, 1'b1);
   endtask

   // Register above the maximum acts as the maximum order.
   task automatic test_size_above_max();
      write_size(3'd7);
      send_element(16'sh0200, 1'b0);
      send_element(16'shFF00, 1'b1);
      write_size(3'd4);
   endtask

   // Mostly well-formed matrices with random content and random order;
   // some short, some overlong, and the odd burst of stray beats.
   task automatic test_random_matrices();
      int unsigned    n;
      int unsigned    count;
      int unsigned    extra;
      int unsigned    strays;
      int unsigned    r;
      fill_style_type style;
      while (random_beats < RAND_BEATS) begin
         if ($urandom_range(0, 9) == 0)
            write_size(CSR_W'($urandom_range(0, 7)));
         else if ($urandom_range(0, 29) == 0)
            wait_drained();
         no_idle = ($urandom_range(0, 6) == 0);
         style   = fill_style_type'($urandom_range(0, 3));
         n       = active_order();
         count   = n * n;
         extra   = 0;
         r       = $urandom_range(0, 99);
         if (r < 10 && count > 1)
            count = $urandom_range(1, count - 1);
         else if (r < 16)
            extra = $urandom_range(1, 3);
         for (int unsigned i = 0; i < count + extra; i++)
            send_element(pick_element(style), i == count + extra - 1);
         random_beats += count + extra;
         if (r >= 96) begin
            // stray beats with random last bits
            strays = $urandom_range(1, 3);
            for (int unsigned i = 0; i < strays; i++)
               send_element(pick_element(FILL_UNIFORM), 1'($urandom_range(0, 1)));
            random_beats += strays;
         end
      end
      no_idle = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      size_csr      = ORDER_MAX;
      elements_held = 0;
      for (int i = 1; i <= ORDER_MAX; i++)
         order_hits[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_full_order();
      test_short_matrix();
      test_order_one();
      test_order_two();
      test_size_change_mid_matrix();
      test_size_above_max();
      test_random_matrices();

      wait_drained();

      $display("checked %0d determinants from %0d beats, %0d saturated",
               dets_checked, beats_sent, saturations);
      $display("orders 1..4 seen: %0d %0d %0d %0d",
               order_hits[1], order_hits[2], order_hits[3], order_hits[4]);
      if (mismatches == 0) begin
         $display("matrix_determinant_cofactor_top: match");
      end else begin
         $display("matrix_determinant_cofactor_top: mismatch");
      end
      $finish;
   end

endmodule
